// File: rtl/core/mcg_pkg.sv
// Package for the midpoint circle generator: default coordinate width and
// the eight-way mirror pattern used when points are emitted.
// No dependencies.
package mcg_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   localparam int MIRROR_COUNT = 8;
   localparam int MIRROR_IDX_BITS = $clog2(MIRROR_COUNT);
   localparam logic [MIRROR_IDX_BITS-1:0] MIRROR_LAST = MIRROR_IDX_BITS'(MIRROR_COUNT - 1);

   // Bit k describes the k-th emitted point of a step. The order is
   // (+x,+y) (+y,+x) (-x,+y) (-y,+x) (+x,-y) (+y,-x) (-x,-y) (-y,-x).
   localparam logic [MIRROR_COUNT-1:0] MIRROR_NEG_X = 8'b1100_1100;
   localparam logic [MIRROR_COUNT-1:0] MIRROR_NEG_Y = 8'b1111_0000;
   localparam logic [MIRROR_COUNT-1:0] MIRROR_SWAP  = 8'b1010_1010;

endpackage

// File: rtl/core/mcg_step.sv
// Midpoint step unit: holds the circle state (center, x, y, decision) and
// computes the state after one accepted item. Depends on mcg_pkg for its default width.
module mcg_step #(
   parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] center_y,
   input  logic        [COORD_BITS-2:0] radius,
   output logic                         emit,
   output logic signed [COORD_BITS-1:0] run_cx,
   output logic signed [COORD_BITS-1:0] run_cy,
   output logic        [COORD_BITS-2:0] run_x,
   output logic        [COORD_BITS-2:0] run_y,
   output logic                         run_done
);

   localparam int DW = COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] center_x_ff, center_x_in;
   logic signed [COORD_BITS-1:0] center_y_ff, center_y_in;
   logic        [COORD_BITS-2:0] step_x_ff, step_x_in;
   logic        [COORD_BITS-2:0] step_y_ff, step_y_in;
   logic signed [DW-1:0]         decision_ff, decision_in;
   logic                         active_ff, active_in;

   logic [COORD_BITS-2:0] x_inc;
   logic [COORD_BITS-2:0] y_dec;
   logic [DW-1:0]         two_x_plus_one;
   logic [DW-1:0]         two_y;

   always_comb begin
      x_inc = step_x_ff + 1'b1;
      y_dec = step_y_ff - 1'b1;
      two_x_plus_one = DW'({1'b0, x_inc, 1'b1});
      two_y = DW'({y_dec, 1'b0});

      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      decision_in = decision_ff;
      active_in = active_ff;
      emit = 1'b0;

      if (start) begin
         center_x_in = center_x;
         center_y_in = center_y;
         step_x_in = '0;
         step_y_in = radius;
         decision_in = DW'(1) - DW'(radius);
         active_in = (radius != '0);
         emit = 1'b1;
      end else if (!active_ff || !(step_x_ff < step_y_ff)) begin
         active_in = 1'b0;
      end else begin
         step_x_in = x_inc;
         if (decision_ff[DW-1]) begin
            decision_in = decision_ff + $signed(two_x_plus_one);
         end else begin
            step_y_in = y_dec;
            decision_in = decision_ff + $signed(two_x_plus_one) - $signed(two_y);
         end
         active_in = (step_x_in < step_y_in);
         emit = 1'b1;
      end
   end

   assign run_cx = center_x_in;
   assign run_cy = center_y_in;
   assign run_x = step_x_in;
   assign run_y = step_y_in;
   assign run_done = !active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         step_x_ff <= '0;
         step_y_ff <= '0;
         decision_ff <= '0;
         active_ff <= 1'b0;
      end else if (load) begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         decision_ff <= decision_in;
         active_ff <= active_in;
      end
   end

endmodule

// File: rtl/core/mcg_emit.sv
// Point emitter: holds one step's center and (x, y) and sends its eight
// mirrored points through an output register. Depends on mcg_pkg.
module mcg_emit #(
   parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load_run,
   input  logic signed [COORD_BITS-1:0] run_cx,
   input  logic signed [COORD_BITS-1:0] run_cy,
   input  logic        [COORD_BITS-2:0] run_x,
   input  logic        [COORD_BITS-2:0] run_y,
   input  logic                         run_done,
   output logic                         can_load,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS:0]   point_x,
   output logic signed [COORD_BITS:0]   point_y,
   output logic                         last_of_run,
   output logic                         arc_done
);

   logic signed [COORD_BITS-1:0] cx_ff;
   logic signed [COORD_BITS-1:0] cy_ff;
   logic        [COORD_BITS-2:0] x_ff;
   logic        [COORD_BITS-2:0] y_ff;
   logic                         done_ff;
   logic                         busy_ff;
   logic [mcg_pkg::MIRROR_IDX_BITS-1:0] idx_ff;

   logic                       out_valid_ff;
   logic signed [COORD_BITS:0] point_x_ff, point_x_in;
   logic signed [COORD_BITS:0] point_y_ff, point_y_in;
   logic                       last_ff;
   logic                       arc_done_ff;

   logic                       advance;
   logic [COORD_BITS-2:0]      a_sel;
   logic [COORD_BITS-2:0]      b_sel;
   logic signed [COORD_BITS:0] cx_ext;
   logic signed [COORD_BITS:0] cy_ext;
   logic signed [COORD_BITS:0] a_ext;
   logic signed [COORD_BITS:0] b_ext;

   // The output register moves on when it is empty or its beat is taken.
   assign advance = !out_valid_ff || out_ready;
   assign can_load = !busy_ff || (advance && idx_ff == mcg_pkg::MIRROR_LAST);

   always_comb begin
      a_sel = mcg_pkg::MIRROR_SWAP[idx_ff] ? y_ff : x_ff;
      b_sel = mcg_pkg::MIRROR_SWAP[idx_ff] ? x_ff : y_ff;
      cx_ext = {cx_ff[COORD_BITS-1], cx_ff};
      cy_ext = {cy_ff[COORD_BITS-1], cy_ff};
      a_ext = $signed({2'b00, a_sel});
      b_ext = $signed({2'b00, b_sel});
      point_x_in = mcg_pkg::MIRROR_NEG_X[idx_ff] ? cx_ext - a_ext : cx_ext + a_ext;
      point_y_in = mcg_pkg::MIRROR_NEG_Y[idx_ff] ? cy_ext - b_ext : cy_ext + b_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= busy_ff;
         end
         // A new run may load in the same cycle as the eighth point loads into the output register.
         if (load_run) begin
            busy_ff <= 1'b1;
            idx_ff <= '0;
         end else if (advance && busy_ff) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == mcg_pkg::MIRROR_LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && busy_ff) begin
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
         last_ff <= (idx_ff == mcg_pkg::MIRROR_LAST);
         arc_done_ff <= done_ff;
      end
      if (load_run) begin
         cx_ff <= run_cx;
         cy_ff <= run_cy;
         x_ff <= run_x;
         y_ff <= run_y;
         done_ff <= run_done;
      end
   end

   assign out_valid = out_valid_ff;
   assign point_x = point_x_ff;
   assign point_y = point_y_ff;
   assign last_of_run = last_ff;
   assign arc_done = arc_done_ff;

endmodule

// File: rtl/core/midpoint_circle_generator.sv
// Midpoint circle generator: a start beat (tuser = 1) loads the center and
// radius and yields the eight mirrored points of (0, r); each advance beat
// (tuser = 0) takes one midpoint step and yields the eight mirrored points of
// the new (x, y), with tuser on the results marking the end of the octant.
// An advance with no circle in progress is absorbed with no result. Every
// other beat produces eight result beats, one per cycle while rsp_tready
// holds, through the single result channel; the input beat loads the
// emitter's hold registers, each point then passes through the output register,
// and the next input beat is taken as the eighth point of the previous one loads.
// Depends on mcg_pkg, mcg_step and mcg_emit.
module midpoint_circle_generator #(
   parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // center_x, center_y, radius from bit 0 up, zero padded to whole bytes
   input  logic [((3*COORD_BITS-1+7)/8)*8-1:0] req_tdata,
   // start_req
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // point_x, point_y from bit 0 up, zero padded to whole bytes
   output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] rsp_tdata,
   // last_of_run
   output logic rsp_tlast,
   // arc_done
   output logic rsp_tuser
);

   localparam int RSP_W = ((2*(COORD_BITS+1)+7)/8)*8;
   localparam int RSP_USED = 2*(COORD_BITS+1);

   logic                         accept;
   logic                         emit;
   logic                         can_load;
   logic signed [COORD_BITS-1:0] in_cx;
   logic signed [COORD_BITS-1:0] in_cy;
   logic        [COORD_BITS-2:0] in_r;
   logic signed [COORD_BITS-1:0] run_cx;
   logic signed [COORD_BITS-1:0] run_cy;
   logic        [COORD_BITS-2:0] run_x;
   logic        [COORD_BITS-2:0] run_y;
   logic                         run_done;
   logic signed [COORD_BITS:0]   point_x;
   logic signed [COORD_BITS:0]   point_y;

   assign in_cx = req_tdata[COORD_BITS-1:0];
   assign in_cy = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign in_r = req_tdata[3*COORD_BITS-2:2*COORD_BITS];

   assign req_tready = can_load;
   assign accept = req_tvalid && can_load;

   mcg_step #(
      .COORD_BITS(COORD_BITS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .start   (req_tuser),
      .center_x(in_cx),
      .center_y(in_cy),
      .radius  (in_r),
      .emit    (emit),
      .run_cx  (run_cx),
      .run_cy  (run_cy),
      .run_x   (run_x),
      .run_y   (run_y),
      .run_done(run_done)
   );

   mcg_emit #(
      .COORD_BITS(COORD_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_run   (accept && emit),
      .run_cx     (run_cx),
      .run_cy     (run_cy),
      .run_x      (run_x),
      .run_y      (run_y),
      .run_done   (run_done),
      .can_load   (can_load),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .point_x    (point_x),
      .point_y    (point_y),
      .last_of_run(rsp_tlast),
      .arc_done   (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({point_y, point_x});

   // Keeps the packing width tied to the field widths.
   if (RSP_USED > RSP_W) begin : g_width_check
      $error("result beat too narrow");
   end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for midpoint_circle_generator: queued stimulus beats,
// a clocked driver and monitor, and a cycle-free predictor of the eight points.
// Depends on mcg_pkg and the midpoint_circle_generator RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int CW     = mcg_pkg::COORD_BITS_DEFAULT;
   localparam int REQ_W  = ((3*CW-1+7)/8)*8;
   localparam int RSP_W  = ((2*(CW+1)+7)/8)*8;
   localparam int PHASES = 4;

   typedef struct packed {
      bit                   start;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic [CW-2:0]        r;
   } circle_beat_type;

   typedef struct packed {
      int x;
      int y;
      int d;
      int cx;
      int cy;
      bit active;
   } arc_state_type;

   typedef struct packed {
      logic [CW:0] px;
      logic [CW:0] py;
      bit          last;
      bit          done;
   } arc_point_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;  // center_x, center_y, radius from bit 0 up
   logic             req_tuser = 1'b0;  // start_req
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;  // point_x, point_y from bit 0 up
   logic             rsp_tlast;  // last_of_run
   logic             rsp_tuser;  // arc_done

   circle_beat_type pending_beats[$];
   arc_point_type   arc_points[$];
   arc_state_type   plan_arc = '0;   // tracks the stimulus so ignored beats are known
   arc_state_type   dut_arc = '0;    // follows accepted beats for the expected points
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              queued_beats = 0;
   int              failures = 0;
   int              starts_seen = 0;
   int              steps_seen = 0;
   int              ignored_seen = 0;
   int              points_checked = 0;

   midpoint_circle_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // One beat of the rasterizer (a start or a midpoint step); emits tells whether points follow.
   function automatic void trace_arc(inout arc_state_type s, input circle_beat_type b,
                                     output bit emits);
      if (b.start) begin
         s.cx = $signed(b.cx);
         s.cy = $signed(b.cy);
         s.x = 0;
         s.y = int'(b.r);
         s.d = 1 - int'(b.r);
         s.active = (s.x < s.y);
         emits = 1'b1;
      end else if (!s.active || !(s.x < s.y)) begin
         s.active = 1'b0;
         emits = 1'b0;
      end else begin
         s.x = s.x + 1;
         if (s.d < 0) begin
            s.d = s.d + 2*s.x + 1;
         end else begin
            s.y = s.y - 1;
            s.d = s.d + 2*s.x + 1 - 2*s.y;
         end
         s.active = (s.x < s.y);
         emits = 1'b1;
      end
   endfunction

   task automatic queue_octant_points(input arc_state_type s);
      int            a;
      int            b;
      arc_point_type p;
      for (int k = 0; k < mcg_pkg::MIRROR_COUNT; k++) begin
         a = mcg_pkg::MIRROR_SWAP[k] ? s.y : s.x;
         b = mcg_pkg::MIRROR_SWAP[k] ? s.x : s.y;
         p.px = (CW+1)'(mcg_pkg::MIRROR_NEG_X[k] ? s.cx - a : s.cx + a);
         p.py = (CW+1)'(mcg_pkg::MIRROR_NEG_Y[k] ? s.cy - b : s.cy + b);
         p.last = (k == mcg_pkg::MIRROR_COUNT - 1);
         p.done = !(s.x < s.y);
         arc_points = {arc_points, p};
      end
   endtask

   task automatic queue_beat(input bit start, input int cx, input int cy, input int r);
      circle_beat_type b;
      bit              emits;
      b.start = start;
      b.cx = CW'(cx);
      b.cy = CW'(cy);
      b.r = (CW-1)'(r);
      trace_arc(plan_arc, b, emits);
      queued_beats++;
      pending_beats = {pending_beats, b};
   endtask

   // Driver: a new beat may only replace the current one once it was taken.
   always @(posedge clock) begin
      circle_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            b = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= b.start;
            req_tdata <= REQ_W'({b.r, b.cy, b.cx});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: check the result beat first, then predict from the input beat.
   always @(posedge clock) begin
      arc_point_type   want;
      circle_beat_type b;
      bit              emits;
      if (!reset && rsp_tvalid && rsp_tready) begin
         points_checked++;
         if (arc_points.size() == 0) begin
            $error("unexpected point beat x=%0d y=%0d", $signed(rsp_tdata[CW:0]),
                   $signed(rsp_tdata[2*CW+1:CW+1]));
            failures++;
         end else begin
            want = arc_points.pop_front();
            if (rsp_tdata[CW:0] !== want.px) begin
               $error("point_x: expected %0d, got %0d", $signed(want.px),
                      $signed(rsp_tdata[CW:0]));
               failures++;
            end
            if (rsp_tdata[2*CW+1:CW+1] !== want.py) begin
               $error("point_y: expected %0d, got %0d", $signed(want.py),
                      $signed(rsp_tdata[2*CW+1:CW+1]));
               failures++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %0b, got %0b", want.last, rsp_tlast);
               failures++;
            end
            if (rsp_tuser !== want.done) begin
               $error("arc_done: expected %0b, got %0b", want.done, rsp_tuser);
               failures++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         b.start = req_tuser;
         b.cx = req_tdata[CW-1:0];
         b.cy = req_tdata[2*CW-1:CW];
         b.r = req_tdata[3*CW-2:2*CW];
         trace_arc(dut_arc, b, emits);
         if (emits)
            queue_octant_points(dut_arc);
         if (b.start)
            starts_seen++;
         else if (emits)
            steps_seen++;
         else
            ignored_seen++;
      end
   end

   initial begin
      int phase_goal;
      int sel;
      int r;
      int cut;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes of the center and radius, zero radius, idle advances.
      queue_beat(0, 0, 0, 0);
      queue_beat(1, -2048, 2047, 0);
      queue_beat(0, 5, 5, 5);
      queue_beat(1, 2047, -2048, 1);
      queue_beat(0, 0, 0, 0);
      queue_beat(0, 0, 0, 0);
      queue_beat(1, -1, -1, 2047);
      queue_beat(0, 0, 0, 0);
      queue_beat(0, 0, 0, 0);
      queue_beat(1, -2048, -2048, 2047);
      queue_beat(0, 0, 0, 0);
      queue_beat(1, 2047, 2047, 2047);
      queue_beat(0, -1, -1, 2047);
      queue_beat(1, 0, 0, 5);
      while (plan_arc.active)
         queue_beat(0, 0, 0, 0);
      queue_beat(0, 0, 0, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         phase_goal = queued_beats + 98;
         while (queued_beats < phase_goal) begin
            sel = $urandom_range(99);
            if (sel < 80) begin
               // Mostly small circles traced to the end; a large one is cut short.
               r = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(30);
               cut = ($urandom_range(5) == 0) ? $urandom_range(6) : 40;
               queue_beat(1, $urandom_range(4095), $urandom_range(4095), r);
               n = 0;
               while (plan_arc.active && n < cut && queued_beats < phase_goal) begin
                  queue_beat(0, $urandom_range(4095), $urandom_range(4095),
                             $urandom_range(2047));
                  n++;
               end
            end else if (sel < 90) begin
               queue_beat(0, $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(2047));
            end else begin
               queue_beat(1, $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(2047));
               n = $urandom_range(3);
               repeat (n) queue_beat(0, 0, 0, 0);
            end
         end
         while (pending_beats.size() != 0 || req_tvalid || arc_points.size() != 0)
            @(posedge clock);
      end

      repeat (20) @(posedge clock);
      if (arc_points.size() != 0) begin
         $error("%0d expected points never arrived", arc_points.size());
         failures++;
      end
      $display("tb: %0d circles started, %0d midpoint steps, %0d idle advances absorbed",
               starts_seen, steps_seen, ignored_seen);
      $display("tb: %0d point beats checked over %0d idling phases", points_checked, PHASES);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/mcg_pkg.sv
rtl/core/mcg_step.sv
rtl/core/mcg_emit.sv
rtl/core/midpoint_circle_generator.sv
sim/testbench.sv
